[src/acp_pkg.sv]
// Shared types, constants and helpers for the ANSI color line parser.
`default_nettype none

package acp_pkg;

    // Longest keyword that the match chain covers.
    localparam int KEYWORD_MAX = 8;
    localparam int KW_BITS     = 8 * KEYWORD_MAX;
    localparam int CFG_DATA_W  = 64;

    // Output queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // Input operation codes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Result kinds.
    localparam logic RK_TEXT   = 1'b0;
    localparam logic RK_REPORT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_KW_BYTES  = 1'b0;
    localparam logic CFG_KW_LENGTH = 1'b1;

    // Byte codes.
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Length of the "38;2;" prefix.
    localparam logic [2:0] PREFIX_LEN = 3'd5;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_SEQ  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_PEND  = 2'd0,
        ST_MATCH = 2'd1,
        ST_FAIL  = 2'd2
    } t_status;

    // Events driven into the sequence parser.
    typedef struct packed {
        logic open;
        logic step;
        logic close;
        logic clear;
    } t_seq_ctl;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text;
        logic [23:0] color;
        logic        hit;
        logic        last;
    } t_result;

    // Expected byte of the "38;2;" prefix at a given position.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h33;  // '3'
            3'd1:    ch = 8'h38;  // '8'
            3'd2:    ch = CH_SEMI;
            3'd3:    ch = 8'h32;  // '2'
            default: ch = CH_SEMI;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[src/acp_kw_cell.sv]
// One cell of the keyword match chain: a byte of recent text and its compare.
`default_nettype none

module acp_kw_cell (
    input  wire logic       i_clk,
    input  wire logic [1:0] i_shift,    // 0, 1 or 2 bytes enter this cycle
    input  wire logic [7:0] i_prev_q,   // neighbor byte (cell 0: first new byte)
    input  wire logic [7:0] i_prev_s1,  // neighbor after one shift (cell 0: second byte)
    input  wire logic [7:0] i_kw_byte,
    input  wire logic       i_care,
    output logic      [7:0] o_q,
    output logic      [7:0] o_s1,
    output logic            o_eq1,
    output logic            o_eq2
);
    logic [7:0] r_byte;

    assign o_q   = r_byte;
    assign o_s1  = i_prev_q;
    // Window after the first and after the second new byte.
    assign o_eq1 = !i_care || (i_prev_q == i_kw_byte);
    assign o_eq2 = !i_care || (i_prev_s1 == i_kw_byte);

    always_ff @(posedge i_clk) begin
        case (i_shift)
            2'd1:    r_byte <= i_prev_q;
            2'd2:    r_byte <= i_prev_s1;
            default: r_byte <= r_byte;
        endcase
    end

endmodule

`default_nettype wire

[src/acp_seq.sv]
// SGR parameter parser: "38;2;R;G;B" recognition and the line color.
`default_nettype none

module acp_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire acp_pkg::t_seq_ctl i_ctl,
    input  wire logic        [7:0] i_byte,
    output logic            [23:0] o_color
);
    import acp_pkg::*;

    logic [2:0]  r_pos,   n_pos;
    logic [1:0]  r_idx,   n_idx;
    logic        r_digit, n_digit;
    logic        r_neg,   n_neg;
    logic        r_sign,  n_sign;
    logic [7:0]  r_val,   n_val;
    logic [15:0] r_rg,    n_rg;
    t_status     r_stat,  n_stat;
    logic [23:0] r_color, n_color;
    logic        r_taken, n_taken;

    logic       w_is_digit;
    logic       w_is_blank;
    logic [7:0] w_signed;
    logic [7:0] w_times10;
    logic       w_ok;

    assign w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_is_blank = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign w_signed   = r_neg ? 8'(8'd0 - r_val) : r_val;
    assign w_times10  = {r_val[4:0], 3'b000} + {r_val[6:0], 1'b0};
    assign w_ok       = (r_stat == ST_MATCH) ||
                        ((r_stat == ST_PEND) && (r_pos == PREFIX_LEN) &&
                         (r_idx == 2'd2) && r_digit);
    assign o_color    = r_color;

    always_comb begin
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_digit = r_digit;
        n_neg   = r_neg;
        n_sign  = r_sign;
        n_val   = r_val;
        n_rg    = r_rg;
        n_stat  = r_stat;
        n_color = r_color;
        n_taken = r_taken;
        if (i_ctl.clear || i_ctl.open) begin
            n_pos   = '0;
            n_idx   = '0;
            n_digit = 1'b0;
            n_neg   = 1'b0;
            n_sign  = 1'b0;
            n_val   = '0;
            n_rg    = '0;
            n_stat  = ST_PEND;
            if (i_ctl.clear) begin
                n_color = '0;
                n_taken = 1'b0;
            end
        end else if (i_ctl.close) begin
            // first color in a line wins
            if (w_ok && !r_taken) begin
                n_color = {r_rg, w_signed};
                n_taken = 1'b1;
            end
        end else if (i_ctl.step && (r_stat == ST_PEND)) begin
            if (r_pos < PREFIX_LEN) begin
                if (i_byte == prefix_char(r_pos)) begin
                    n_pos = r_pos + 3'd1;
                end else begin
                    n_stat = ST_FAIL;
                end
            end else if (w_is_digit) begin
                n_val   = w_times10 + 8'(i_byte - CH_ZERO);
                n_digit = 1'b1;
            end else if (r_digit) begin
                if ((r_idx < 2'd2) && (i_byte == CH_SEMI)) begin
                    n_rg    = {r_rg[7:0], w_signed};
                    n_idx   = r_idx + 2'd1;
                    n_digit = 1'b0;
                    n_neg   = 1'b0;
                    n_sign  = 1'b0;
                    n_val   = '0;
                end else if (r_idx == 2'd2) begin
                    n_stat = ST_MATCH;  // trailing text after blue is ignored
                end else begin
                    n_stat = ST_FAIL;
                end
            end else if (!r_sign && w_is_blank) begin
                n_stat = r_stat;        // leading blank
            end else if (!r_sign && ((i_byte == CH_PLUS) || (i_byte == CH_MINUS))) begin
                n_sign = 1'b1;
                n_neg  = (i_byte == CH_MINUS);
            end else begin
                n_stat = ST_FAIL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_idx   <= '0;
            r_digit <= 1'b0;
            r_neg   <= 1'b0;
            r_sign  <= 1'b0;
            r_val   <= '0;
            r_rg    <= '0;
            r_stat  <= ST_PEND;
            r_color <= '0;
            r_taken <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_idx   <= n_idx;
            r_digit <= n_digit;
            r_neg   <= n_neg;
            r_sign  <= n_sign;
            r_val   <= n_val;
            r_rg    <= n_rg;
            r_stat  <= n_stat;
            r_color <= n_color;
            r_taken <= n_taken;
        end
    end

endmodule

`default_nettype wire

[src/acp_outq.sv]
// Result queue: takes up to two results a cycle, hands out one while the output is not stalled.
`default_nettype none

module acp_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic       [1:0] i_push_n,
    input  wire acp_pkg::t_result i_push0,
    input  wire acp_pkg::t_result i_push1,
    output logic                  o_space_ok,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output acp_pkg::t_result      o_head
);
    import acp_pkg::*;

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr;
    logic [OQ_AW-1:0] r_rd;
    logic [OQ_AW:0]   r_count;
    logic             w_pop;
    logic [OQ_AW-1:0] w_wr1;

    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rd];
    assign w_pop      = o_valid && !i_stall;
    assign o_space_ok = (r_count <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign w_wr1      = r_wr + OQ_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr1] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + OQ_AW'(i_push_n);
            r_rd    <= r_rd + OQ_AW'(w_pop);
            r_count <= r_count + (OQ_AW+1)'(i_push_n) - (OQ_AW+1)'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("output queue overflow");

endmodule

`default_nettype wire

[src/ansi_color_line_parser_top.sv]
// Top level of the ANSI color line parser: escape control, match chain, result queue.
`default_nettype none

// Log bytes enter one per clock while the input is not stalled and are cut into
// lines at a newline or a flush request; a line with no raw byte gives nothing.
// ESC [ ... m sequences are removed, a lone ESC stays as text, and an unclosed
// sequence drops the rest of the line. Visible bytes leave at once as text
// results; each non-empty line ends with one report that carries the line color
// (first "38;2;R;G;B" of the line, black by default) and whether the keyword (up
// to 8 bytes, set through the config port while idle) occurred in the line text.
// Rate: one input request per clock while not stalled. A request gives zero, one
// or two results; two arise only where a held lone ESC is released together with
// the next byte or with the line end report. Results go through a four-entry
// queue that drains one per clock while the output is not stalled, and the input
// stalls while fewer than two entries are free, so the output port is what limits
// throughput when a request yields two results. Keyword matching runs in a chain
// of eight byte cells that shift the recent text along and each compare one
// keyword position; no clearing pass is needed after reset.
module ansi_color_line_parser_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [acp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input requests
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [7:0]                     i_data_byte,
    // results
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_result_kind,
    output logic [7:0]                          o_text_byte,
    output logic [23:0]                         o_line_color,
    output logic                                o_keyword_hit,
    output logic                                o_last_result
);
    import acp_pkg::*;

    // Configuration registers.
    logic [KW_BITS-1:0] r_kw_bytes;
    logic [3:0]         r_kw_length;

    // Line state.
    t_phase     r_phase, n_phase;
    logic       r_line_open;
    logic [3:0] r_seen;
    logic       r_found;

    // Per-request decode.
    logic       w_acc;
    logic       w_is_end;
    logic [1:0] w_emit_cnt;
    logic [7:0] w_e1;
    logic [7:0] w_e2;
    logic       w_report;
    t_seq_ctl   w_seq;

    // Keyword matching.
    logic [3:0]         w_len;
    logic [KW_BITS-1:0] w_kw_al;
    logic [3:0]         w_seen1;
    logic [3:0]         w_seen2;
    logic [KEYWORD_MAX-1:0] w_eq1;
    logic [KEYWORD_MAX-1:0] w_eq2;
    logic [7:0]         w_q  [KEYWORD_MAX];
    logic [7:0]         w_s1 [KEYWORD_MAX];
    logic [1:0]         w_shift;
    logic               w_f1;
    logic               w_f2;
    logic               w_found_now;
    logic               w_hit;

    // Results.
    logic [23:0] w_color;
    logic [1:0]  w_total;
    t_result     w_txt1, w_txt2, w_rep, w_push0, w_push1, w_head;
    logic        w_space_ok;

    assign o_in_stall = !w_space_ok;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_is_end   = (i_operation == OP_FLUSH) || (i_data_byte == CH_LF);

    // ---------------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_bytes  <= '0;
            r_kw_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KW_BYTES:  r_kw_bytes  <= i_cfg_data[KW_BITS-1:0];
                CFG_KW_LENGTH: r_kw_length <= i_cfg_data[3:0];
                default:       r_kw_length <= r_kw_length;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Escape phase: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            if (w_is_end) begin
                n_phase = PH_TEXT;
            end else begin
                unique case (r_phase)
                    PH_TEXT: begin
                        if (i_data_byte == CH_ESC) n_phase = PH_ESC;
                    end
                    PH_ESC: begin
                        if (i_data_byte == CH_LBR) begin
                            n_phase = PH_SEQ;
                        end else if (i_data_byte != CH_ESC) begin
                            n_phase = PH_TEXT;
                        end
                    end
                    PH_SEQ: begin
                        if (i_data_byte == CH_M) n_phase = PH_TEXT;
                    end
                    default: n_phase = PH_TEXT;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Escape phase: outputs (text emits, report, parser events)
    // ---------------------------------------------------------------------
    always_comb begin
        w_emit_cnt = 2'd0;
        w_e1       = i_data_byte;
        w_e2       = i_data_byte;
        w_report   = 1'b0;
        w_seq      = '0;
        if (w_acc) begin
            if (w_is_end) begin
                if (r_line_open) begin
                    w_report   = 1'b1;
                    w_seq.clear = 1'b1;
                    // a held ESC leaves ahead of the report
                    if (r_phase == PH_ESC) begin
                        w_emit_cnt = 2'd1;
                        w_e1       = CH_ESC;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_TEXT: begin
                        if (i_data_byte != CH_ESC) w_emit_cnt = 2'd1;
                    end
                    PH_ESC: begin
                        if (i_data_byte == CH_LBR) begin
                            w_seq.open = 1'b1;
                        end else if (i_data_byte == CH_ESC) begin
                            w_emit_cnt = 2'd1;
                            w_e1       = CH_ESC;
                        end else begin
                            w_emit_cnt = 2'd2;
                            w_e1       = CH_ESC;
                        end
                    end
                    PH_SEQ: begin
                        if (i_data_byte == CH_M) begin
                            w_seq.close = 1'b1;
                        end else begin
                            w_seq.step = 1'b1;
                        end
                    end
                    default: w_emit_cnt = 2'd0;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Keyword match chain
    // ---------------------------------------------------------------------
    assign w_len   = (r_kw_length > 4'(KEYWORD_MAX)) ? 4'(KEYWORD_MAX) : r_kw_length;
    // Align the keyword so that cell i always compares a fixed byte lane.
    assign w_kw_al = r_kw_bytes << {4'(KEYWORD_MAX) - w_len, 3'b000};
    assign w_seen1 = (r_seen >= 4'(KEYWORD_MAX)) ? 4'(KEYWORD_MAX) : r_seen + 4'd1;
    assign w_seen2 = (w_seen1 >= 4'(KEYWORD_MAX)) ? 4'(KEYWORD_MAX) : w_seen1 + 4'd1;
    assign w_shift = w_emit_cnt;

    for (genvar gi = 0; gi < KEYWORD_MAX; gi++) begin : g_cell
        logic [7:0] w_in_q;
        logic [7:0] w_in_s1;
        if (gi == 0) begin : g_head
            assign w_in_q  = w_e1;
            assign w_in_s1 = w_e2;
        end else begin : g_body
            assign w_in_q  = w_q[gi-1];
            assign w_in_s1 = w_s1[gi-1];
        end
        acp_kw_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_shift),
            .i_prev_q  (w_in_q),
            .i_prev_s1 (w_in_s1),
            .i_kw_byte (w_kw_al[8*(KEYWORD_MAX-1-gi) +: 8]),
            .i_care    (4'(gi) < w_len),
            .o_q       (w_q[gi]),
            .o_s1      (w_s1[gi]),
            .o_eq1     (w_eq1[gi]),
            .o_eq2     (w_eq2[gi])
        );
    end

    assign w_f1 = (w_emit_cnt != 2'd0) && (w_len != 4'd0) && (w_seen1 >= w_len) && (&w_eq1);
    assign w_f2 = (w_emit_cnt == 2'd2) && (w_len != 4'd0) && (w_seen2 >= w_len) && (&w_eq2);
    assign w_found_now = r_found || w_f1 || w_f2;
    // empty keyword test uses the length in force at line end
    assign w_hit = w_found_now || (r_kw_length == 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TEXT;
            r_line_open <= 1'b0;
            r_seen      <= '0;
            r_found     <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_acc) begin
                r_line_open <= !w_is_end;
                if (w_report) begin
                    r_seen  <= '0;
                    r_found <= 1'b0;
                end else begin
                    case (w_emit_cnt)
                        2'd1:    r_seen <= w_seen1;
                        2'd2:    r_seen <= w_seen2;
                        default: r_seen <= r_seen;
                    endcase
                    r_found <= w_found_now;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence parser and line color
    // ---------------------------------------------------------------------
    acp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_seq),
        .i_byte  (i_data_byte),
        .o_color (w_color)
    );

    // ---------------------------------------------------------------------
    // Result assembly and queue
    // ---------------------------------------------------------------------
    assign w_total = w_emit_cnt + 2'(w_report);

    always_comb begin
        w_txt1 = '{kind: RK_TEXT, text: w_e1, color: '0, hit: 1'b0, last: 1'b0};
        w_txt2 = '{kind: RK_TEXT, text: w_e2, color: '0, hit: 1'b0, last: 1'b1};
        w_rep  = '{kind: RK_REPORT, text: '0, color: w_color, hit: w_hit, last: 1'b1};
        w_push0      = (w_emit_cnt != 2'd0) ? w_txt1 : w_rep;
        w_push0.last = (w_total == 2'd1);
        w_push1      = (w_emit_cnt == 2'd2) ? w_txt2 : w_rep;
    end

    acp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (w_total),
        .i_push0    (w_push0),
        .i_push1    (w_push1),
        .o_space_ok (w_space_ok),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_head     (w_head)
    );

    assign o_result_kind = w_head.kind;
    assign o_text_byte   = w_head.text;
    assign o_line_color  = w_head.color;
    assign o_keyword_hit = w_head.hit;
    assign o_last_result = w_head.last;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_closed_line_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_line_open |-> (r_phase == PH_TEXT))
        else $error("escape phase active with no open line");

    a_found_needs_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen == 4'd0) |-> !r_found)
        else $error("keyword found with no text in line");

    a_end_closes_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_end) |=> !r_line_open)
        else $error("line still open after line end request");

    a_report_only_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_report |-> (r_line_open && w_acc))
        else $error("report without an open line");

endmodule

`default_nettype wire

[sim/acp_line_checker.sv]
// Checker for the ANSI color line parser: predicts every result and compares it.
module acp_line_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [acp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic                           i_result_kind,
    input  wire logic [7:0]                     i_text_byte,
    input  wire logic [23:0]                    i_line_color,
    input  wire logic                           i_keyword_hit,
    input  wire logic                           i_last_result,
    output int                                  o_errors,
    output int                                  o_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import acp_pkg::*;

    // number flag bits
    localparam int NF_DIGIT = 0;
    localparam int NF_NEG   = 1;
    localparam int NF_SIGN  = 2;
    localparam logic [39:0] COLOR_PREFIX = "38;2;";

    logic [63:0] kw_bytes;
    logic [3:0]  kw_len_reg;

    logic        line_open;
    t_phase      esc_phase;
    logic [2:0]  prefix_pos;
    logic [1:0]  num_idx;
    logic [2:0]  num_flags;
    logic [7:0]  num_val;
    logic [15:0] rg_held;
    t_status     seq_stat;
    logic [23:0] cur_color;
    logic        color_taken;
    logic [7:0]  recent [KEYWORD_MAX];
    logic [3:0]  text_seen;
    logic        kw_found;

    t_result     line_results_due [$];
    t_result     staged;
    logic        have_staged;
    int          fail_count = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_count++;
        $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic logic [7:0] signed_num();
        return num_flags[NF_NEG] ? 8'd0 - num_val : num_val;
    endfunction

    // Results of one request are held back by one so the last can be marked.
    task automatic stage_result(input t_result r);
        if (have_staged)
            line_results_due.push_back(staged);
        staged      = r;
        have_staged = 1'b1;
    endtask

    task automatic clear_line();
        int i;
        line_open   = 1'b0;
        esc_phase   = PH_TEXT;
        prefix_pos  = '0;
        num_idx     = '0;
        num_flags   = '0;
        num_val     = '0;
        rg_held     = '0;
        seq_stat    = ST_PEND;
        cur_color   = '0;
        color_taken = 1'b0;
        for (i = 0; i < KEYWORD_MAX; i++)
            recent[i] = '0;
        text_seen   = '0;
        kw_found    = 1'b0;
    endtask

    task automatic emit_visible(input logic [7:0] b);
        int   i;
        int   len;
        logic same;
        len = (kw_len_reg > KEYWORD_MAX) ? KEYWORD_MAX : int'(kw_len_reg);
        for (i = KEYWORD_MAX - 1; i > 0; i--)
            recent[i] = recent[i-1];
        recent[0] = b;
        if (text_seen < KEYWORD_MAX)
            text_seen++;
        // newest byte is compared with the last keyword byte
        if (len > 0 && text_seen >= len) begin
            same = 1'b1;
            for (i = 0; i < len; i++)
                if (recent[i] != kw_bytes[8*(len-1-i) +: 8])
                    same = 1'b0;
            if (same)
                kw_found = 1'b1;
        end
        stage_result('{kind: RK_TEXT, text: b, color: 24'd0, hit: 1'b0, last: 1'b0});
    endtask

    task automatic predict_request(input logic op, input logic [7:0] b);
        logic is_digit;
        logic is_blank;
        logic ok;
        have_staged = 1'b0;
        is_digit = b >= CH_ZERO && b <= CH_NINE;
        is_blank = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
        if (op == OP_FLUSH || b == CH_LF) begin
            if (line_open) begin
                if (esc_phase == PH_ESC)
                    emit_visible(CH_ESC);
                stage_result('{kind: RK_REPORT, text: 8'd0,
                               color: color_taken ? cur_color : 24'd0,
                               hit: kw_found || kw_len_reg == 0, last: 1'b0});
                clear_line();
            end
        end else begin
            line_open = 1'b1;
            case (esc_phase)
                PH_TEXT: begin
                    if (b == CH_ESC)
                        esc_phase = PH_ESC;
                    else
                        emit_visible(b);
                end
                PH_ESC: begin
                    if (b == CH_LBR) begin
                        esc_phase  = PH_SEQ;
                        prefix_pos = '0;
                        num_idx    = '0;
                        num_flags  = '0;
                        num_val    = '0;
                        rg_held    = '0;
                        seq_stat   = ST_PEND;
                    end else if (b == CH_ESC) begin
                        emit_visible(CH_ESC);
                    end else begin
                        emit_visible(CH_ESC);
                        emit_visible(b);
                        esc_phase = PH_TEXT;
                    end
                end
                default: begin
                    if (b == CH_M) begin
                        ok = seq_stat == ST_MATCH ||
                             (seq_stat == ST_PEND && prefix_pos == PREFIX_LEN &&
                              num_idx == 2 && num_flags[NF_DIGIT]);
                        // first color of the line wins
                        if (ok && !color_taken) begin
                            cur_color   = {rg_held, signed_num()};
                            color_taken = 1'b1;
                        end
                        esc_phase = PH_TEXT;
                    end else if (seq_stat == ST_PEND) begin
                        if (prefix_pos < PREFIX_LEN) begin
                            if (b == COLOR_PREFIX[8*(4-prefix_pos) +: 8])
                                prefix_pos++;
                            else
                                seq_stat = ST_FAIL;
                        end else if (is_digit) begin
                            num_val = num_val * 8'd10 + (b - CH_ZERO);
                            num_flags[NF_DIGIT] = 1'b1;
                        end else if (num_flags[NF_DIGIT]) begin
                            if (num_idx < 2 && b == CH_SEMI) begin
                                rg_held   = {rg_held[7:0], signed_num()};
                                num_idx++;
                                num_flags = '0;
                                num_val   = '0;
                            end else if (num_idx == 2) begin
                                seq_stat = ST_MATCH;  // rest after blue ignored
                            end else begin
                                seq_stat = ST_FAIL;
                            end
                        end else if (!num_flags[NF_SIGN] && is_blank) begin
                            // leading blank
                        end else if (!num_flags[NF_SIGN] && (b == CH_PLUS || b == CH_MINUS)) begin
                            num_flags[NF_SIGN] = 1'b1;
                            if (b == CH_MINUS)
                                num_flags[NF_NEG] = 1'b1;
                        end else begin
                            seq_stat = ST_FAIL;
                        end
                    end
                end
            endcase
        end
        if (have_staged) begin
            staged.last = 1'b1;
            line_results_due.push_back(staged);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            kw_bytes   = '0;
            kw_len_reg = '0;
            clear_line();
            line_results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (line_results_due.size() == 0) begin
                    flag_mismatch("result with nothing expected", i_text_byte, 0);
                end else begin
                    want = line_results_due.pop_front();
                    if (i_result_kind !== want.kind)
                        flag_mismatch("result_kind", i_result_kind, want.kind);
                    if (i_text_byte !== want.text)
                        flag_mismatch("text_byte", i_text_byte, want.text);
                    if (i_line_color !== want.color)
                        flag_mismatch("line_color", i_line_color, want.color);
                    if (i_keyword_hit !== want.hit)
                        flag_mismatch("keyword_hit", i_keyword_hit, want.hit);
                    if (i_last_result !== want.last)
                        flag_mismatch("last_result", i_last_result, want.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_KW_BYTES)
                    kw_bytes = i_cfg_data;
                else
                    kw_len_reg = i_cfg_data[3:0];
            end
            if (i_in_valid && !i_in_stall)
                predict_request(i_operation, i_data_byte);
        end
        o_due    <= line_results_due.size();
        o_errors <= fail_count;
    end

endmodule

[sim/tb.sv]
// Testbench top for the ANSI color line parser: stimulus, config phases, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acp_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 240;   // about 1900 random requests overall

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_index = CFG_KW_BYTES;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_operation = OP_DATA;
    logic [7:0]            i_data_byte = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_result_kind;
    logic [7:0]            o_text_byte;
    logic [23:0]           o_line_color;
    logic                  o_keyword_hit;
    logic                  o_last_result;

    int          fail_total;
    int          due_count;
    int          sent          = 0;
    int          in_idle_pct   = 30;
    int          out_stall_pct = 30;
    logic [63:0] cur_keyword   = '0;
    logic [7:0]  seq_bytes [$];    // bytes of the line being built

    ansi_color_line_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_text_byte   (o_text_byte),
        .o_line_color  (o_line_color),
        .o_keyword_hit (o_keyword_hit),
        .o_last_result (o_last_result)
    );

    acp_line_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_data_byte   (i_data_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_result_kind (o_result_kind),
        .i_text_byte   (o_text_byte),
        .i_line_color  (o_line_color),
        .i_keyword_hit (o_keyword_hit),
        .i_last_result (o_last_result),
        .o_errors      (fail_total),
        .o_due         (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall, redrawn every clock.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // One request: random idle clocks first, then hold until not stalled.
    // Payload only moves after acceptance.
    task automatic send_request(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sent++;
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_request(OP_DATA, s[i]);
    endtask

    // Stop sending until every expected result is out, then give the block
    // time for requests that had no result (held ESC, sequence bytes).
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_keyword(input logic [63:0] kw, input logic [3:0] len);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_KW_BYTES;
        i_cfg_data  <= kw;
        @(posedge i_clk);
        i_cfg_index <= CFG_KW_LENGTH;
        i_cfg_data  <= 64'(len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_keyword = kw;
    endtask

    // Text byte biased toward keyword bytes so matches actually happen.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        int         pos;
        pos = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0:       b = cur_keyword[8*pos +: 8];
            1:       b = 8'($urandom_range(0, 255));
            default: b = 8'h61 + 8'($urandom_range(0, 4));
        endcase
        if (b == CH_LF || b == CH_ESC)
            b = 8'h61;
        return b;
    endfunction

    // One color number: optional blanks, optional sign, decimal digits.
    task automatic add_number();
        string digits;
        int    i;
        int    r;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                r = $urandom_range(0, 5);
                seq_bytes.push_back(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
            end
        end
        case ($urandom_range(0, 3))
            0:       seq_bytes.push_back(CH_PLUS);
            1:       seq_bytes.push_back(CH_MINUS);
            default: ;
        endcase
        digits = $sformatf("%0d", ($urandom_range(0, 3) == 0) ?
                           $urandom_range(0, 99999) : $urandom_range(0, 255));
        for (i = 0; i < digits.len(); i++)
            seq_bytes.push_back(digits[i]);
    endtask

    // Random line: mostly text and well-formed color sequences, the rest other
    // SGR codes, lone ESCs, raw noise and broken or unclosed sequences.
    task automatic send_random_line();
        int    kind;
        int    n;
        int    start;
        string pre;
        string sgr_chars;
        pre       = "38;2;";
        sgr_chars = "0123456789;";
        repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 6))
                        seq_bytes.push_back(pick_text_byte());
                end
                4: begin
                    for (n = 0; n < KEYWORD_MAX; n++)
                        seq_bytes.push_back(cur_keyword[8*n +: 8]);
                end
                5, 6, 7: begin
                    start = seq_bytes.size();
                    seq_bytes.push_back(CH_ESC);
                    seq_bytes.push_back(CH_LBR);
                    for (n = 0; n < pre.len(); n++)
                        seq_bytes.push_back(pre[n]);
                    add_number();
                    seq_bytes.push_back(CH_SEMI);
                    add_number();
                    seq_bytes.push_back(CH_SEMI);
                    add_number();
                    // trailing junk after blue is legal
                    if ($urandom_range(0, 2) == 0)
                        repeat ($urandom_range(1, 2))
                            seq_bytes.push_back(8'h78 + 8'($urandom_range(0, 2)));
                    seq_bytes.push_back(CH_M);
                    if (kind == 7) begin
                        if ($urandom_range(0, 1) == 0)
                            seq_bytes[$urandom_range(start + 1, seq_bytes.size() - 1)] =
                                8'($urandom_range(0, 255));
                        else
                            void'(seq_bytes.pop_back());   // left unclosed
                    end
                end
                8: begin
                    seq_bytes.push_back(CH_ESC);
                    seq_bytes.push_back(CH_LBR);
                    repeat ($urandom_range(0, 4))
                        seq_bytes.push_back(sgr_chars[$urandom_range(0, 10)]);
                    seq_bytes.push_back(CH_M);
                end
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        seq_bytes.push_back(CH_ESC);
                    seq_bytes.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        foreach (seq_bytes[i])
            send_request(OP_DATA, seq_bytes[i]);
        seq_bytes.delete();
        if ($urandom_range(0, 1) == 0)
            send_request(OP_DATA, CH_LF);
        else
            send_request(OP_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int          phase;
        int          phase_end;
        int          n;
        logic [63:0] kw;
        logic [3:0]  len;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset keyword (empty, so every line hits).
        // Flush with no open line: nothing comes out.
        send_request(OP_FLUSH, 8'hFF);
        // Extreme bytes, ESC ESC (first released alone), ESC + plain byte.
        send_request(OP_DATA, 8'h00);
        send_request(OP_DATA, 8'hFF);
        send_string("\033\033q\n");
        // Color with blank, negative and wrapping numbers plus trailing junk,
        // then a lone ESC left hanging at a flush.
        send_string("\033[38;2;\t-1;+300;7xm\033");
        send_request(OP_FLUSH, 8'h00);
        // Unclosed sequence swallows the rest of the line.
        send_string("\033[9\n");

        for (phase = 0; phase < PHASES; phase++) begin
            for (n = 0; n < KEYWORD_MAX; n++)
                kw[8*n +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                               8'h61 + 8'($urandom_range(0, 4));
            case (phase)
                0:       len = 4'd3;
                1: begin kw = '1; len = 4'd15; end   // over range counts as 8
                2: begin kw = '0; len = 4'd8;  end
                3:       len = 4'd0;
                4:       len = 4'd1;
                default: len = 4'($urandom_range(0, 15));
            endcase
            // every line is closed before the write: the keyword changes between lines
            program_keyword(kw, len);
            // one phase runs with no idling on either side
            in_idle_pct   = (phase == 3) ? 0 : 30;
            out_stall_pct = (phase == 3) ? 0 : 30;
            phase_end = sent + PHASE_REQS;
            while (sent < phase_end) begin
                send_random_line();
                if ($urandom_range(0, 39) == 0)
                    settle();
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_total == 0 && due_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
